[rtl/pra_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pra_pkg
// Shared types and constants of the page run allocator.
// ---------------------------------------------------------------------------
package pra_pkg;

  localparam int PAGE_W        = 14;
  localparam int COUNT_W       = 15;
  localparam int TOTAL_PAGES   = 16384;
  localparam int RUN_SLOTS_DEF = 256;

  typedef enum logic {
    OP_TAKE = 1'b0,
    OP_GIVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_LEAKED   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_LAST_RD,
    S_LAST_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  start;
    logic [COUNT_W-1:0] length;
  } run_entry_t;

  typedef struct packed {
    logic [PAGE_W-1:0] first_page;
    status_t           status;
  } result_t;

endpackage
`default_nettype wire

[rtl/page_run_allocator.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// page_run_allocator
// First-fit page run allocator with a free-run table and a bump pointer.
//
// One request word enters on the in_ channel (opcode, start_page,
// page_count) and exactly one result word leaves on the out_ channel
// (first_page, status). A word moves when valid is high and stall is low.
// Requests are handled one at a time: in_stall stays low only while the
// sequencer is idle, and a new request is taken even while the previous
// result still waits in the output register.
// The table sits in a single-port-read memory that the scan walks one
// entry per cycle over the live table entries. A take that empties a
// run other than the last moves the last entry into its slot through
// S_LAST_RD and S_LAST_WR.
// Reset clears the bump pointer and the entry count; the table needs no
// clearing pass. While out_stall is high the result is held and the
// sequencer waits before reporting the next one.
// ---------------------------------------------------------------------------
module page_run_allocator
  import pra_pkg::*;
#(
  parameter int RUN_SLOTS = RUN_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_opcode,
  input  wire logic [PAGE_W-1:0]  in_start_page,
  input  wire logic [COUNT_W-1:0] in_page_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [PAGE_W-1:0]       out_first_page,
  output logic [1:0]              out_status
);

  localparam int IDX_W = $clog2(RUN_SLOTS);

  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             mem_re, mem_we;
  logic [IDX_W-1:0] mem_raddr, mem_waddr;
  run_entry_t       mem_rdata, mem_wdata;

  logic             out_valid_r, out_valid_nxt;
  result_t          out_r, out_nxt;

  pra_ctrl #(
    .RUN_SLOTS (RUN_SLOTS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_opcode     (in_opcode),
    .in_start_page (in_start_page),
    .in_page_count (in_page_count),
    .in_stall      (in_stall),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata)
  );

  pra_run_mem #(
    .RUN_SLOTS (RUN_SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register frees when empty or when its word is taken
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_first_page = out_r.first_page;
  assign out_status     = out_r.status;

endmodule
`default_nettype wire

[rtl/pra_run_mem.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pra_run_mem
// Free-run table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pra_run_mem
  import pra_pkg::*;
#(
  parameter int RUN_SLOTS = RUN_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(RUN_SLOTS)-1:0] waddr,
  input  wire run_entry_t                   wdata,
  input  wire logic                         re,
  input  wire logic [$clog2(RUN_SLOTS)-1:0] raddr,
  output run_entry_t                        rdata
);

  run_entry_t mem [RUN_SLOTS];
  run_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/pra_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pra_ctrl
// Request sequencer: scans the run table, carves or merges runs, moves the
// bump pointer and forms one result word per request.
// ---------------------------------------------------------------------------
module pra_ctrl
  import pra_pkg::*;
#(
  parameter int RUN_SLOTS = RUN_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_opcode,
  input  wire logic [PAGE_W-1:0]            in_start_page,
  input  wire logic [COUNT_W-1:0]           in_page_count,
  output logic                              in_stall,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output result_t                           res,
  output logic                              mem_re,
  output logic [$clog2(RUN_SLOTS)-1:0]      mem_raddr,
  input  wire run_entry_t                   mem_rdata,
  output logic                              mem_we,
  output logic [$clog2(RUN_SLOTS)-1:0]      mem_waddr,
  output run_entry_t                        mem_wdata
);

  localparam int IDX_W = $clog2(RUN_SLOTS);
  localparam int CNT_W = $clog2(RUN_SLOTS + 1);
  localparam logic [COUNT_W:0] TOTAL_X = (COUNT_W + 1)'(TOTAL_PAGES);
  localparam logic [CNT_W-1:0] SLOTS_X = CNT_W'(RUN_SLOTS);

  // control state
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [COUNT_W-1:0]  bump_r, bump_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;

  // payload
  opcode_t             op_r, op_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  result_t             res_r, res_nxt;

  logic [COUNT_W:0]    give_sum;
  logic [COUNT_W-1:0]  give_end;
  logic [COUNT_W:0]    bump_sum;
  logic [COUNT_W:0]    run_end;
  logic [COUNT_W-1:0]  carve_start;
  logic [COUNT_W-1:0]  carve_len;
  logic [COUNT_W-1:0]  grown_len;
  logic [CNT_W-1:0]    total_dec;
  logic                hit_take, hit_after, hit_before, issue;

  assign give_sum    = {2'b00, page_r} + {1'b0, count_r};
  assign give_end    = give_sum[COUNT_W-1:0];
  assign bump_sum    = {1'b0, bump_r} + {1'b0, count_r};
  assign run_end     = {2'b00, mem_rdata.start} + {1'b0, mem_rdata.length};
  assign carve_start = {1'b0, mem_rdata.start} + count_r;
  assign carve_len   = mem_rdata.length - count_r;
  assign grown_len   = mem_rdata.length + count_r;
  assign total_dec   = total_r - CNT_W'(1);

  assign hit_take   = rd_vld_r && (op_r == OP_TAKE) && (mem_rdata.length >= count_r);
  assign hit_after  = rd_vld_r && (op_r == OP_GIVE) && (run_end == {2'b00, page_r});
  assign hit_before = rd_vld_r && (op_r == OP_GIVE) && (give_end == {1'b0, mem_rdata.start});
  assign issue      = (state_r == S_SCAN) && !(hit_take || hit_after || hit_before)
                      && (idx_r < total_r);

  always_comb begin
    state_nxt   = state_r;
    total_nxt   = total_r;
    bump_nxt    = bump_r;
    rd_vld_nxt  = 1'b0;
    idx_nxt     = idx_r;
    op_nxt      = op_r;
    page_nxt    = page_r;
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    hit_idx_nxt = hit_idx_r;
    res_nxt     = res_r;
    in_stall    = 1'b1;
    res_valid   = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = idx_r[IDX_W-1:0];
    mem_we      = 1'b0;
    mem_waddr   = rd_idx_r;
    mem_wdata   = mem_rdata;

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_nxt    = opcode_t'(in_opcode);
          page_nxt  = in_start_page;
          count_nxt = in_page_count;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        res_nxt.first_page = '0;
        res_nxt.status     = ST_OK;
        idx_nxt            = '0;
        state_nxt          = S_SCAN;
        if (op_r == OP_TAKE) begin
          if (count_r == '0) begin
            res_nxt.status = ST_NO_SPACE;
            state_nxt      = S_RESP;
          end
        end else if ((count_r == '0) || (give_sum > TOTAL_X)) begin
          state_nxt = S_RESP;
        end else if (give_end == bump_r) begin
          // returned run sits just below the bump pointer: pull it back
          bump_nxt  = {1'b0, page_r};
          state_nxt = S_RESP;
        end
      end

      S_SCAN: begin
        // one read issued per cycle, checked in the next cycle in table order
        mem_re     = issue;
        rd_vld_nxt = issue;
        rd_idx_nxt = idx_r[IDX_W-1:0];
        if (issue) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (hit_take) begin
          res_nxt.first_page = mem_rdata.start;
          res_nxt.status     = ST_OK;
          state_nxt          = S_RESP;
          if (carve_len != '0) begin
            mem_we           = 1'b1;
            mem_wdata.start  = carve_start[PAGE_W-1:0];
            mem_wdata.length = carve_len;
          end else begin
            total_nxt = total_dec;
            if (CNT_W'(rd_idx_r) != total_dec) begin
              // fill the emptied slot from the last entry
              hit_idx_nxt = rd_idx_r;
              state_nxt   = S_LAST_RD;
            end
          end
        end else if (hit_after) begin
          mem_we           = 1'b1;
          mem_wdata.length = grown_len;
          state_nxt        = S_RESP;
        end else if (hit_before) begin
          mem_we           = 1'b1;
          mem_wdata.start  = page_r;
          mem_wdata.length = grown_len;
          state_nxt        = S_RESP;
        end else if (!rd_vld_r && !issue) begin
          state_nxt = S_RESP;
          if (op_r == OP_TAKE) begin
            if (bump_sum > TOTAL_X) begin
              res_nxt.status = ST_NO_SPACE;
            end else begin
              res_nxt.first_page = bump_r[PAGE_W-1:0];
              bump_nxt           = bump_sum[COUNT_W-1:0];
            end
          end else if (total_r < SLOTS_X) begin
            mem_we           = 1'b1;
            mem_waddr        = total_r[IDX_W-1:0];
            mem_wdata.start  = page_r;
            mem_wdata.length = count_r;
            total_nxt        = total_r + CNT_W'(1);
          end else begin
            res_nxt.status = ST_LEAKED;
          end
        end
      end

      S_LAST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = total_r[IDX_W-1:0];
        state_nxt = S_LAST_WR;
      end

      S_LAST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx_r;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      total_r  <= '0;
      bump_r   <= '0;
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      bump_r   <= bump_nxt;
      rd_vld_r <= rd_vld_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    page_r    <= page_nxt;
    count_r   <= count_nxt;
    rd_idx_r  <= rd_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    res_r     <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire
